/* rtl/sha1bh_pkg.sv */
`timescale 1ns / 1ps

package sha1bh_pkg;

   localparam int WordWidth   = 32;
   localparam int BlockWords  = 16;
   localparam int DigestWords = 5;
   localparam int Rounds      = 80;
   localparam int PhaseRounds = 20;
   localparam int QueueDepth  = 2;

   typedef logic [WordWidth-1:0] word_type;

   typedef struct packed {
      word_type message_word;
      logic     first_block;
      logic     final_block;
   } req_type;

   typedef struct packed {
      word_type digest_word;
      logic     last_word;
   } rsp_type;

   typedef struct packed {
      word_type [BlockWords-1:0] words;
      logic                      first_block;
      logic                      final_block;
   } block_type;

   localparam word_type [DigestWords-1:0] InitValue = {
      32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };

   localparam word_type [3:0] RoundConst = {
      32'hca62c1d6, 32'h8f1bbcdc, 32'h6ed9eba1, 32'h5a827999
   };

   localparam logic [1:0] PhaseChoose     = 2'd0;
   localparam logic [1:0] PhaseParity     = 2'd1;
   localparam logic [1:0] PhaseMajor      = 2'd2;
   localparam logic [1:0] PhaseParityLate = 2'd3;

   function automatic word_type round_func(input logic [1:0] phase, input word_type b,
                                           input word_type c, input word_type d);
      word_type f;
      case (phase)
         PhaseChoose: f = (b & c) | (~b & d);
         PhaseMajor:  f = (b & c) | (b & d) | (c & d);
         PhaseParity: f = b ^ c ^ d;
         default:     f = b ^ c ^ d;
      endcase
      return f;
   endfunction

endpackage

/* rtl/sha1bh_front.sv */
`timescale 1ns / 1ps

module sha1bh_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  sha1bh_pkg::req_type   req_data,
   output logic                  blk_valid,
   output sha1bh_pkg::block_type blk_data,
   input  logic                  blk_ready
);
   import sha1bh_pkg::*;

   localparam int CountWidth = $clog2(BlockWords);

   logic [CountWidth-1:0] count_ff, count_in;
   word_type [BlockWords-2:0] words_ff, words_in;
   logic last_beat;
   logic accept;

   assign last_beat = (count_ff == CountWidth'(BlockWords - 1));
   assign req_full  = last_beat && !blk_ready;
   assign accept    = req_push && !req_full;
   assign blk_valid = req_push && last_beat;

   assign blk_data.words       = {req_data.message_word, words_ff};
   assign blk_data.first_block = req_data.first_block;
   assign blk_data.final_block = req_data.final_block;

   always_comb begin
      count_in = count_ff;
      words_in = words_ff;
      if (accept) begin
         count_in = count_ff + CountWidth'(1);
         for (int k = 0; k < BlockWords - 2; k++) begin
            words_in[k] = words_ff[k+1];
         end
         words_in[BlockWords-2] = req_data.message_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
   end

endmodule

/* rtl/sha1bh_queue.sv */
`timescale 1ns / 1ps

module sha1bh_queue #(
   parameter int Depth = sha1bh_pkg::QueueDepth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_valid,
   input  sha1bh_pkg::block_type wr_block,
   output logic                  wr_ready,
   output logic                  rd_valid,
   output sha1bh_pkg::block_type rd_block,
   input  logic                  rd_take
);
   import sha1bh_pkg::*;

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);

   block_type             slot_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_wr;
   logic                  do_rd;

   assign wr_ready = (count_ff != CntWidth'(Depth));
   assign rd_valid = (count_ff != '0);
   assign rd_block = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_take && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      count_in = count_ff + CntWidth'(do_wr) - CntWidth'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_block;
      end
   end

endmodule

/* rtl/sha1bh_back.sv */
`timescale 1ns / 1ps

module sha1bh_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  blk_valid,
   input  sha1bh_pkg::block_type blk_data,
   output logic                  blk_take,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output sha1bh_pkg::rsp_type   rsp_data
);
   import sha1bh_pkg::*;

   localparam int RoundWidth = $clog2(Rounds);
   localparam int IdxWidth   = $clog2(DigestWords);

   logic                     busy_ff, busy_in;
   logic [RoundWidth-1:0]    round_ff, round_in;
   logic                     final_ff, final_in;
   word_type [BlockWords-1:0] sched_ff, sched_in;
   word_type [DigestWords-1:0] work_ff, work_in;
   word_type [DigestWords-1:0] chain_ff, chain_in;
   word_type [DigestWords-1:0] dig_ff, dig_in;
   logic                     out_busy_ff, out_busy_in;
   logic [IdxWidth-1:0]      out_idx_ff, out_idx_in;

   logic [1:0]               phase;
   word_type                 next_w;
   word_type                 mix;
   word_type                 temp;
   word_type [DigestWords-1:0] work_next;
   word_type [DigestWords-1:0] chain_start;
   logic                     last_round;
   logic                     last_out;
   logic                     do_pop;

   assign blk_take  = blk_valid && !busy_ff && !out_busy_ff;
   assign rsp_empty = !out_busy_ff;
   assign last_out  = (out_idx_ff == IdxWidth'(DigestWords - 1));
   assign do_pop    = rsp_pop && out_busy_ff;
   assign rsp_data.digest_word = dig_ff[0];
   assign rsp_data.last_word   = last_out;
   assign last_round = busy_ff && (round_ff == RoundWidth'(Rounds - 1));

   always_comb begin
      if (round_ff < RoundWidth'(PhaseRounds)) begin
         phase = PhaseChoose;
      end else if (round_ff < RoundWidth'(2 * PhaseRounds)) begin
         phase = PhaseParity;
      end else if (round_ff < RoundWidth'(3 * PhaseRounds)) begin
         phase = PhaseMajor;
      end else begin
         phase = PhaseParityLate;
      end
   end

   // The window holds W[t] .. W[t+15]; the word shifted in is W[t+16].
   assign mix    = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];
   assign next_w = {mix[WordWidth-2:0], mix[WordWidth-1]};

   assign temp = {work_ff[0][WordWidth-6:0], work_ff[0][WordWidth-1:WordWidth-5]}
               + round_func(phase, work_ff[1], work_ff[2], work_ff[3])
               + work_ff[4] + sched_ff[0] + RoundConst[phase];

   always_comb begin
      work_next[0] = temp;
      work_next[1] = work_ff[0];
      work_next[2] = {work_ff[1][1:0], work_ff[1][WordWidth-1:2]};
      work_next[3] = work_ff[2];
      work_next[4] = work_ff[3];
   end

   assign chain_start = blk_data.first_block ? InitValue : chain_ff;

   always_comb begin
      busy_in     = busy_ff;
      round_in    = round_ff;
      final_in    = final_ff;
      sched_in    = sched_ff;
      work_in     = work_ff;
      chain_in    = chain_ff;
      dig_in      = dig_ff;
      out_busy_in = out_busy_ff;
      out_idx_in  = out_idx_ff;

      if (blk_take) begin
         busy_in  = 1'b1;
         round_in = '0;
         final_in = blk_data.final_block;
         sched_in = blk_data.words;
         work_in  = chain_start;
         chain_in = chain_start;
      end else if (busy_ff) begin
         work_in  = work_next;
         round_in = round_ff + RoundWidth'(1);
         for (int k = 0; k < BlockWords - 1; k++) begin
            sched_in[k] = sched_ff[k+1];
         end
         sched_in[BlockWords-1] = next_w;
         if (last_round) begin
            busy_in = 1'b0;
            for (int k = 0; k < DigestWords; k++) begin
               chain_in[k] = chain_ff[k] + work_next[k];
            end
            if (final_ff) begin
               dig_in      = chain_in;
               out_busy_in = 1'b1;
               out_idx_in  = '0;
            end
         end
      end

      if (do_pop) begin
         for (int k = 0; k < DigestWords - 1; k++) begin
            dig_in[k] = dig_ff[k+1];
         end
         dig_in[DigestWords-1] = dig_ff[DigestWords-1];
         out_idx_in = out_idx_ff + IdxWidth'(1);
         if (last_out) begin
            out_busy_in = 1'b0;
            out_idx_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         round_ff    <= '0;
         out_busy_ff <= 1'b0;
         out_idx_ff  <= '0;
         chain_ff    <= InitValue;
      end else begin
         busy_ff     <= busy_in;
         round_ff    <= round_in;
         out_busy_ff <= out_busy_in;
         out_idx_ff  <= out_idx_in;
         chain_ff    <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      final_ff <= final_in;
      sched_ff <= sched_in;
      work_ff  <= work_in;
      dig_ff   <= dig_in;
   end

endmodule

/* rtl/sha1_block_hash_top.sv */
`timescale 1ns / 1ps
// Message words are taken at one per cycle while req_full is low; a completed block
// waits in a small block queue. Each block occupies the single round engine for one
// load step and 80 rounds; a new block is taken only when the engine is idle and no
// digest is waiting to be popped. The digest is offered after the final block's last round.
// Synchronous active-high reset drops any partial block and restores the initial chain value.
module sha1_block_hash_top #(
   parameter int QueueDepth = sha1bh_pkg::QueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  sha1bh_pkg::req_type req_data,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output sha1bh_pkg::rsp_type rsp_data
);
   import sha1bh_pkg::*;

   logic      front_valid;
   block_type front_block;
   logic      queue_ready;
   logic      queue_valid;
   block_type queue_block;
   logic      back_take;

   sha1bh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .blk_valid (front_valid),
      .blk_data  (front_block),
      .blk_ready (queue_ready)
   );

   sha1bh_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_block (front_block),
      .wr_ready (queue_ready),
      .rd_valid (queue_valid),
      .rd_block (queue_block),
      .rd_take  (back_take)
   );

   sha1bh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .blk_valid (queue_valid),
      .blk_data  (queue_block),
      .blk_take  (back_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

/* dv/tb_sha1_block_hash_top.sv */
`timescale 1ns / 1ps

module tb_sha1_block_hash_top;
   import sha1bh_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   sha1_block_hash_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   req_type  word_stream[$];
   rsp_type  expected_digest[$];
   word_type chain_h[DigestWords];
   word_type sched_w[BlockWords];
   int       word_index = 0;
   int       words_total = 0;
   int       words_taken = 0;
   int       digest_beats = 0;
   int       error_count = 0;
   int       send_gap = 0;
   int       pop_gap = 0;
   int       hold_left = 0;
   bit       hold_done = 1'b0;
   int       calm_left[2] = '{0, 0};
   int       send_draw;
   int       pop_draw;

   function automatic word_type rotate_left(word_type x, int n);
      return (x << n) | (x >> (WordWidth - n));
   endfunction

   function automatic void compress_block();
      word_type   a, b, c, d, e, f, w, t;
      logic [1:0] phase;
      a = chain_h[0];
      b = chain_h[1];
      c = chain_h[2];
      d = chain_h[3];
      e = chain_h[4];
      for (int r = 0; r < Rounds; r++) begin
         if (r < BlockWords) begin
            w = sched_w[r];
         end else begin
            w = rotate_left(sched_w[(r - 3) & 15] ^ sched_w[(r - 8) & 15] ^
                            sched_w[(r - 14) & 15] ^ sched_w[r & 15], 1);
            sched_w[r & 15] = w;
         end
         phase = 2'(r / PhaseRounds);
         case (phase)
            PhaseChoose: f = (b & c) | (~b & d);
            PhaseMajor:  f = (b & c) | (b & d) | (c & d);
            default:     f = b ^ c ^ d;
         endcase
         t = rotate_left(a, 5) + f + e + w + RoundConst[phase];
         e = d;
         d = c;
         c = rotate_left(b, 30);
         b = a;
         a = t;
      end
      chain_h[0] += a;
      chain_h[1] += b;
      chain_h[2] += c;
      chain_h[3] += d;
      chain_h[4] += e;
   endfunction

   function automatic void absorb_word(req_type beat);
      rsp_type digest;
      sched_w[word_index] = beat.message_word;
      if (word_index != BlockWords - 1) begin
         word_index++;
         return;
      end
      word_index = 0;
      if (beat.first_block) begin
         for (int k = 0; k < DigestWords; k++) chain_h[k] = InitValue[k];
      end
      compress_block();
      if (beat.final_block) begin
         for (int k = 0; k < DigestWords; k++) begin
            digest.digest_word = chain_h[k];
            digest.last_word = (k == DigestWords - 1);
            expected_digest.push_back(digest);
         end
      end
   endfunction

   function automatic int pick_gap(int side);
      int roll;
      if (calm_left[side] != 0) begin
         calm_left[side]--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         calm_left[side] = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(string what, word_type seen, word_type wanted);
      $display("mismatch at %0t: %s seen %08h wanted %08h", $time, what, seen, wanted);
      error_count++;
   endtask

   task automatic queue_block(int style, bit first, bit final_flag, bit noisy_flags);
      req_type beat;
      for (int i = 0; i < BlockWords; i++) begin
         case (style)
            1:       beat.message_word = '0;
            2:       beat.message_word = '1;
            3:       beat.message_word = $urandom_range(0, 1) ? '1 : '0;
            4:       beat.message_word = (i == 0) ? 32'h61626380 :
                                         (i == BlockWords - 1) ? 32'h18 : '0;
            default: beat.message_word = $urandom;
         endcase
         if (i == BlockWords - 1 && !noisy_flags) begin
            beat.first_block = first;
            beat.final_block = final_flag;
         end else begin
            beat.first_block = $urandom_range(0, 1);
            beat.final_block = $urandom_range(0, 1);
         end
         word_stream.push_back(beat);
      end
   endtask

   for (genvar g = 0; g < 1; g++) begin : g_init_chain
      initial begin
         for (int k = 0; k < DigestWords; k++) chain_h[k] = InitValue[k];
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         send_gap <= 0;
      end else if (req_push && !req_full) begin
         absorb_word(req_data);
         words_taken <= words_taken + 1;
         send_draw = pick_gap(0);
         if (send_draw != 0 || word_stream.size() == 0) begin
            req_push <= 1'b0;
            send_gap <= send_draw;
         end else begin
            req_data <= word_stream.pop_front();
         end
      end else if (!req_push) begin
         if (send_gap != 0) begin
            send_gap <= send_gap - 1;
         end else if (word_stream.size() != 0) begin
            req_push <= 1'b1;
            req_data <= word_stream.pop_front();
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_gap <= 0;
      end else if (rsp_pop && !rsp_empty) begin
         digest_beats <= digest_beats + 1;
         if (expected_digest.size() == 0) begin
            report_mismatch("unexpected digest beat", rsp_data.digest_word, '0);
         end else begin
            if (rsp_data.digest_word !== expected_digest[0].digest_word)
               report_mismatch("digest_word", rsp_data.digest_word,
                               expected_digest[0].digest_word);
            if (rsp_data.last_word !== expected_digest[0].last_word)
               report_mismatch("last_word", word_type'(rsp_data.last_word),
                               word_type'(expected_digest[0].last_word));
            void'(expected_digest.pop_front());
         end
         pop_draw = pick_gap(1);
         pop_gap <= pop_draw;
         rsp_pop <= (pop_draw == 0) && (hold_left == 0);
      end else if (hold_left != 0 || pop_gap != 0) begin
         rsp_pop <= 1'b0;
         if (pop_gap != 0) pop_gap <= pop_gap - 1;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Once a couple of digests have drained, the receiver stops for a long
   // stretch so that the block queue fills and the input side stalls.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && digest_beats >= 2 * DigestWords) begin
         hold_left <= 1500;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   initial begin
      int  blocks;
      int  roll;
      bit  missing_first;
      queue_block(4, 1'b1, 1'b1, 1'b0);
      while (word_stream.size() < 312) begin
         blocks = $urandom_range(1, 3);
         missing_first = ($urandom_range(0, 9) == 0);
         for (int b = 0; b < blocks; b++) begin
            roll = $urandom_range(0, 9);
            queue_block((roll < 4) ? roll : 0, (b == 0) && !missing_first,
                        b == blocks - 1, $urandom_range(0, 9) == 0);
         end
      end
      words_total = word_stream.size();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (words_taken < words_total) @(posedge clock);
      while (expected_digest.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("sha1_block_hash_top regression: pass");
      end else begin
         $display("sha1_block_hash_top regression: fail");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("sha1_block_hash_top regression: fail");
      $finish;
   end

endmodule

/* files.f */
rtl/sha1bh_pkg.sv
rtl/sha1bh_front.sv
rtl/sha1bh_queue.sv
rtl/sha1bh_back.sv
rtl/sha1_block_hash_top.sv
dv/tb_sha1_block_hash_top.sv
